### design/pel_pkg.sv
// Package for the positional entry list: widths, request and status codes,
// the entry and per-cycle command types shared by the cell row and top level.
// No dependencies.
package pel_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 5;
  localparam int CMP_W  = (POS_W > CNT_W + 1) ? POS_W : CNT_W + 1;
  localparam int ID_W   = 16;
  localparam int PRI_W  = 8;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;
  localparam int LCNT_W = 5;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef logic [CNT_W:0]   wide_t;
  typedef logic [CMP_W-1:0] cmp_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INS_HEAD = 3'd0,
    REQ_INS_TAIL = 3'd1,
    REQ_INS_POS  = 3'd2,
    REQ_REM_HEAD = 3'd3,
    REQ_REM_TAIL = 3'd4,
    REQ_REM_POS  = 3'd5
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } pel_entry_t;

  // broadcast to every cell in the accept cycle
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] k;
    logic [CNT_W-1:0] count;
  } pel_cmd_t;

endpackage

### design/pel_cell.sv
// One slot of the entry row: holds an id and priority, loads a new entry,
// or takes its left or right neighbor's entry on insert or remove.
// Depends on pel_pkg.
module pel_cell import pel_pkg::*; (
  input  logic             clk,
  input  pel_cmd_t         cmd,
  input  logic [IDX_W-1:0] idx,
  input  pel_entry_t       new_entry,
  input  pel_entry_t       left,
  input  pel_entry_t       right,
  output pel_entry_t       held
);

  wide_t i_x;
  wide_t k_x;
  wide_t c_x;

  assign i_x = wide_t'(idx);
  assign k_x = wide_t'(cmd.k);
  assign c_x = wide_t'(cmd.count);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (i_x == k_x) begin
        held <= new_entry;
      end else if (i_x > k_x && i_x <= c_x) begin
        held <= left;
      end
    end else if (cmd.rem) begin
      if (i_x >= k_x && (i_x + 1'b1) < c_x) begin
        held <= right;
      end
    end
  end

endmodule

### design/positional_entry_list_unit.sv
// Top level of the positional entry list: request decode, count register,
// the row of pel_cell slots and the result register.
// Depends on pel_pkg and pel_cell.

// Holds an ordered list of up to DEPTH entries (id, priority) in a row of
// cells, slot 0 being the head. Each request inserts at the head, the tail or
// before a 1-based position, or removes from the head, the tail or a
// position, and returns one result: status, removed entry (zero if none) and
// the count afterward. All cells of the row update together: each shifts
// toward or away from the chosen slot, so a new request is taken every
// cycle while the result register is free or being emptied.
module positional_entry_list_unit import pel_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [TYPE_W-1:0] req_type,
  input  logic [POS_W-1:0]  position,
  input  logic [ID_W-1:0]   entry_id,
  input  logic [PRI_W-1:0]  entry_priority,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [STAT_W-1:0] status,
  output logic [ID_W-1:0]   removed_id,
  output logic [PRI_W-1:0]  removed_priority,
  output logic [LCNT_W-1:0] list_count
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fire;
  logic             ins_ok;
  logic             rem_ok;
  logic [IDX_W-1:0] k;
  status_t          status_next;
  pel_cmd_t         cmd;
  pel_entry_t       new_entry;
  pel_entry_t       slots [DEPTH];
  pel_entry_t       taken;
  cmp_t             pos_x;
  cmp_t             cnt_x;
  logic             full;
  logic             empty;

  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;
  assign pos_x     = cmp_t'(position);
  assign cnt_x     = cmp_t'(count);
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);
  assign new_entry = '{id: entry_id, pri: entry_priority};

  always_comb begin
    ins_ok      = 1'b0;
    rem_ok      = 1'b0;
    k           = '0;
    status_next = ST_OK;
    unique case (req_type)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (req_type == REQ_INS_HEAD || empty) begin
          ins_ok = 1'b1;
        end else if (req_type == REQ_INS_TAIL) begin
          ins_ok = 1'b1;
          k      = IDX_W'(count);
        end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
          status_next = ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
          k      = IDX_W'(pos_x - 1'b1);
        end
      end
      REQ_REM_HEAD, REQ_REM_TAIL, REQ_REM_POS: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (req_type == REQ_REM_HEAD) begin
          rem_ok = 1'b1;
        end else if (req_type == REQ_REM_TAIL) begin
          rem_ok = 1'b1;
          k      = IDX_W'(count - 1'b1);
        end else if (pos_x == '0 || pos_x > cnt_x) begin
          status_next = ST_BADPOS;
        end else begin
          rem_ok = 1'b1;
          k      = IDX_W'(pos_x - 1'b1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  assign cmd = '{ins: fire && ins_ok, rem: fire && rem_ok, k: k, count: count};

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.rem) begin
      count_next = count - 1'b1;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      pel_entry_t left_in;
      pel_entry_t right_in;
      if (i == 0) begin : g_first
        assign left_in = '0;
      end else begin : g_left
        assign left_in = slots[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_right
        assign right_in = slots[i+1];
      end
      pel_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .idx       (IDX_W'(i)),
        .new_entry (new_entry),
        .left      (left_in),
        .right     (right_in),
        .held      (slots[i])
      );
    end
  endgenerate

  assign taken = rem_ok ? slots[k] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status           <= status_next;
      removed_id       <= taken.id;
      removed_priority <= taken.pri;
      list_count       <= LCNT_W'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + 1'b1)
    else $error("insert did not grow count");

  a_rem_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |=> count == $past(count) - 1'b1)
    else $error("remove did not shrink count");

  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    fire && !rem_ok |=> removed_id == '0 && removed_priority == '0)
    else $error("removed fields set without removal");
`endif

endmodule

### sim/positional_entry_list_unit_tb.sv
// Self-checking testbench for positional_entry_list_unit: a directed plan, then
// phased random traffic with random idling on both sides, checked by a predictor.
// Depends on pel_pkg and the positional_entry_list_unit RTL.
`timescale 1ns / 1ps

module positional_entry_list_unit_tb;
  import pel_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam int NPLAN       = 24;
  localparam int NRANDOM     = 1730;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 400;
  localparam int GAP_PCT     = 38;

  typedef struct packed {
    status_t           st;
    logic [ID_W-1:0]   rid;
    logic [PRI_W-1:0]  rpr;
    logic [LCNT_W-1:0] cnt;
  } outcome_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic              typed;
    outcome_t          want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [TYPE_W-1:0] req_type = '0;
  logic [POS_W-1:0]  position = '0;
  logic [ID_W-1:0]   entry_id = '0;
  logic [PRI_W-1:0]  entry_priority = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   removed_id;
  logic [PRI_W-1:0]  removed_priority;
  logic [LCNT_W-1:0] list_count;

  positional_entry_list_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .req_type(req_type), .position(position),
    .entry_id(entry_id), .entry_priority(entry_priority),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .removed_id(removed_id),
    .removed_priority(removed_priority), .list_count(list_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the list contents, head at index 0
  pel_entry_t held [DEPTH];
  int         held_count = 0;
  int         peak_count = 0;
  outcome_t   pending [$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_badpos = 0;
  bit calm = 1'b0;
  bit hold_rsp = 1'b0;

  plan_row_t plan [NPLAN] = '{
    '{REQ_REM_HEAD,  5'd1,  16'h0000, 8'h00, 1'b1, '{ST_EMPTY,  16'h0, 8'h0, 5'd0}},
    '{REQ_REM_TAIL,  5'd1,  16'h0000, 8'h00, 1'b1, '{ST_EMPTY,  16'h0, 8'h0, 5'd0}},
    '{REQ_REM_POS,   5'd1,  16'h0000, 8'h00, 1'b1, '{ST_EMPTY,  16'h0, 8'h0, 5'd0}},
    '{REQ_INS_POS,   5'd17, 16'h1234, 8'h5a, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd1}},
    '{REQ_INS_HEAD,  5'd0,  16'hffff, 8'hff, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd2}},
    '{REQ_INS_TAIL,  5'd31, 16'h0000, 8'h00, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd3}},
    '{REQ_INS_POS,   5'd0,  16'hdead, 8'h01, 1'b1, '{ST_BADPOS, 16'h0, 8'h0, 5'd3}},
    '{REQ_INS_POS,   5'd5,  16'hdead, 8'h02, 1'b1, '{ST_BADPOS, 16'h0, 8'h0, 5'd3}},
    '{REQ_INS_POS,   5'd4,  16'ha5a5, 8'h3c, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_INS_POS,   5'd1,  16'h0001, 8'h80, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_INS_POS,   5'd3,  16'h7fff, 8'h7f, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_REM_POS,   5'd0,  16'h0000, 8'h00, 1'b1, '{ST_BADPOS, 16'h0, 8'h0, 5'd6}},
    '{REQ_REM_POS,   5'd7,  16'h0000, 8'h00, 1'b1, '{ST_BADPOS, 16'h0, 8'h0, 5'd6}},
    '{REQ_REM_POS,   5'd31, 16'h0000, 8'h00, 1'b1, '{ST_BADPOS, 16'h0, 8'h0, 5'd6}},
    '{REQ_REM_POS,   5'd6,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_REM_POS,   5'd1,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_REM_POS,   5'd2,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_UNUSED_LO, 5'd1,  16'hc0de, 8'h99, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd3}},
    '{REQ_UNUSED_HI, 5'd2,  16'hffff, 8'hff, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd3}},
    '{REQ_REM_HEAD,  5'd0,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_REM_TAIL,  5'd0,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_REM_POS,   5'd1,  16'h0000, 8'h00, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}},
    '{REQ_INS_TAIL,  5'd9,  16'hbeef, 8'h11, 1'b1, '{ST_OK,     16'h0, 8'h0, 5'd1}},
    '{REQ_INS_HEAD,  5'd16, 16'h5555, 8'haa, 1'b0, '{ST_OK,     16'h0, 8'h0, 5'd0}}
  };

  // applies one request to the mirror and returns the result it should give
  function automatic outcome_t apply_request(input logic [TYPE_W-1:0] kind,
                                             input logic [POS_W-1:0] pos,
                                             input logic [ID_W-1:0] id,
                                             input logic [PRI_W-1:0] pri);
    outcome_t res;
    int put_slot;
    int take_slot;
    int j;
    res = '{ST_OK, '0, '0, '0};
    put_slot = -1;
    take_slot = -1;
    if (kind == REQ_INS_HEAD || kind == REQ_INS_TAIL || kind == REQ_INS_POS) begin
      if (held_count >= DEPTH) res.st = ST_FULL;
      else if (kind == REQ_INS_HEAD) put_slot = 0;
      else if (kind == REQ_INS_TAIL) put_slot = held_count;
      else if (held_count == 0) put_slot = 0;
      else if (pos < 1 || pos > held_count + 1) res.st = ST_BADPOS;
      else put_slot = pos - 1;
    end else if (kind == REQ_REM_HEAD || kind == REQ_REM_TAIL || kind == REQ_REM_POS) begin
      if (held_count == 0) res.st = ST_EMPTY;
      else if (kind == REQ_REM_HEAD) take_slot = 0;
      else if (kind == REQ_REM_TAIL) take_slot = held_count - 1;
      else if (pos < 1 || pos > held_count) res.st = ST_BADPOS;
      else take_slot = pos - 1;
    end
    if (put_slot >= 0) begin
      for (j = held_count; j > put_slot; j--) held[j] = held[j-1];
      held[put_slot].id = id;
      held[put_slot].pri = pri;
      held_count++;
    end
    if (take_slot >= 0) begin
      res.rid = held[take_slot].id;
      res.rpr = held[take_slot].pri;
      for (j = take_slot; j + 1 < held_count; j++) held[j] = held[j+1];
      held_count--;
    end
    if (held_count > peak_count) peak_count = held_count;
    res.cnt = held_count[LCNT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on result %0d: %s got %0h want %0h at %0t",
             n_checked, what, got, want, $realtime);
    errors++;
  endtask

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
                           input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
                           input logic typed, input outcome_t typed_want);
    outcome_t want;
    req_valid      <= 1'b1;
    req_type       <= kind;
    position       <= pos;
    entry_id       <= id;
    entry_priority <= pri;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = apply_request(kind, pos, id, pri);
    if (typed) want = typed_want;
    pending.push_back(want);
    n_sent++;
  endtask

  // idle cycles drawn one at a time so the sender idles in about GAP_PCT of cycles
  task automatic maybe_gap(input bit no_gap);
    if (!no_gap) begin
      while ($urandom_range(99) < GAP_PCT) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  initial begin
    int i;
    int phase_left;
    int ins_pct;
    int r;
    int pick;
    logic [TYPE_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    bit no_gap;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NPLAN; i++) begin
      send_item(plan[i].kind, plan[i].pos, plan[i].id, plan[i].pri,
                plan[i].typed, plan[i].want);
      maybe_gap(1'b0);
    end

    phase_left = 0;
    ins_pct = 50;
    for (i = 0; i < NRANDOM; i++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(2))
          0: ins_pct = 88;
          1: ins_pct = 15;
          default: ins_pct = 52;
        endcase
      end
      phase_left--;
      calm = (i >= 900 && i < 1150);
      if (i == 300) hold_rsp = 1'b1;
      no_gap = calm || (i >= 300 && i < 340);

      r = $urandom_range(99);
      pick = $urandom_range(2);
      if (r < 3) begin
        kind = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      end else if (r < ins_pct) begin
        kind = (pick == 0) ? REQ_INS_HEAD : (pick == 1) ? REQ_INS_TAIL : REQ_INS_POS;
      end else begin
        kind = (pick == 0) ? REQ_REM_HEAD : (pick == 1) ? REQ_REM_TAIL : REQ_REM_POS;
      end
      if ($urandom_range(99) < 15) pos = $urandom_range(31);
      else if (kind == REQ_INS_POS) pos = $urandom_range(held_count + 1, 1);
      else pos = $urandom_range((held_count > 0) ? held_count : 1, 1);

      send_item(kind, pos, $urandom_range(16'hffff), $urandom_range(8'hff), 1'b0, '0);
      maybe_gap(no_gap);
    end
    req_valid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("%0d requests sent, %0d results checked, peak list count %0d",
             n_sent, n_checked, peak_count);
    $display("full %0d, empty %0d, bad position %0d; %0d mismatches",
             n_full, n_empty, n_badpos, errors);
    if (errors == 0 && pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off, a calm window
  initial begin
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ready <= calm || ($urandom_range(99) >= GAP_PCT);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending, status", status, 0);
      end else begin
        want = pending.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (removed_id !== want.rid) report_mismatch("removed_id", removed_id, want.rid);
        if (removed_priority !== want.rpr)
          report_mismatch("removed_priority", removed_priority, want.rpr);
        if (list_count !== want.cnt) report_mismatch("list_count", list_count, want.cnt);
        case (want.st)
          ST_FULL:   n_full++;
          ST_EMPTY:  n_empty++;
          ST_BADPOS: n_badpos++;
          default: ;
        endcase
      end
      n_checked++;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
